FILE: src/b64sc_pkg.sv
`timescale 1ns / 1ps

package b64sc_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_BAD_PAD  = 2'd3;

    localparam logic [7:0] PadChar     = 8'h3D;
    localparam logic [7:0] SpaceChar   = 8'h20;
    localparam logic [7:0] NewlineChar = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic [1:0] status;
    } t_out_item;

    // Results caused by one input transaction, slot 0 delivered first.
    typedef struct packed {
        t_out_item [MaxResults-1:0] slot;
        logic [2:0]                 count;
    } t_bundle;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } t_dec_char;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    function automatic t_dec_char dec_char(input logic [7:0] c);
        t_dec_char r;
        r.bad = 1'b0;
        r.pad = 1'b0;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h47);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c + 8'h04);
        end else if (c == 8'h2B) begin
            r.val = 6'd62;
        end else if (c == 8'h2F) begin
            r.val = 6'd63;
        end else if (c == PadChar) begin
            r.pad = 1'b1;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/b64sc_step.sv
`timescale 1ns / 1ps

module b64sc_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_load,
    input  b64sc_pkg::t_in_item i_item,
    output b64sc_pkg::t_bundle  o_bundle
);

    logic        r_mode;
    logic [23:0] r_bits;
    logic [1:0]  r_count;
    logic [1:0]  r_pad;
    logic [1:0]  r_err;
    logic        r_seen;

    logic [23:0] n_bits;
    logic [1:0]  n_count;
    logic [1:0]  n_pad;
    logic [1:0]  n_err;
    logic        n_seen;

    always_comb begin
        b64sc_pkg::t_dec_char dc;
        b64sc_pkg::t_out_item item;
        logic [1:0]           pos;
        logic [5:0]           v;
        logic [2:0]           k;
        logic [7:0]           b;

        n_bits  = r_bits;
        n_count = r_count;
        n_pad   = r_pad;
        n_err   = r_err;
        n_seen  = r_seen;
        o_bundle = '0;
        k  = 3'd0;
        b  = i_item.in_byte;
        dc = b64sc_pkg::dec_char(b);
        v  = dc.val;
        pos = r_count;
        item = '0;
        item.has_byte = 1'b1;

        if (!r_mode) begin
            if (pos == 2'd3) begin
                pos = 2'd0;
            end
            unique case (pos)
                2'd0:    n_bits = r_bits | {b, 16'h0000};
                2'd1:    n_bits = r_bits | {8'h00, b, 8'h00};
                default: n_bits = r_bits | {16'h0000, b};
            endcase
            n_count = pos + 2'd1;
            if (pos == 2'd2 || i_item.in_last) begin
                item.out_byte = b64sc_pkg::enc_char(n_bits[23:18]);
                o_bundle.slot[0] = item;
                item.out_byte = b64sc_pkg::enc_char(n_bits[17:12]);
                o_bundle.slot[1] = item;
                item.out_byte = (pos == 2'd0) ? b64sc_pkg::PadChar
                                              : b64sc_pkg::enc_char(n_bits[11:6]);
                o_bundle.slot[2] = item;
                item.out_byte = (pos == 2'd2) ? b64sc_pkg::enc_char(n_bits[5:0])
                                              : b64sc_pkg::PadChar;
                item.out_last = i_item.in_last;
                o_bundle.slot[3] = item;
                o_bundle.count = 3'd4;
                n_bits  = '0;
                n_count = 2'd0;
            end
        end else begin
            if (b != b64sc_pkg::SpaceChar && b != b64sc_pkg::NewlineChar) begin
                n_seen = 1'b1;
                if (dc.bad) begin
                    n_err = b64sc_pkg::ST_BAD_CHAR;
                end else begin
                    if (dc.pad) begin
                        if (pos < 2'd2) begin
                            if (r_err == b64sc_pkg::ST_OK) begin
                                n_err = b64sc_pkg::ST_BAD_PAD;
                            end
                        end else if (pos == 2'd2) begin
                            n_pad[0] = 1'b1;
                        end else begin
                            n_pad[1] = 1'b1;
                        end
                        v = 6'd0;
                    end
                    n_bits = {r_bits[17:0], v};
                    if (pos == 2'd3) begin
                        // The error cannot change on the fourth character.
                        if (r_err == b64sc_pkg::ST_OK) begin
                            item.out_byte = n_bits[23:16];
                            o_bundle.slot[k[1:0]] = item;
                            k = k + 3'd1;
                            if (!n_pad[0]) begin
                                item.out_byte = n_bits[15:8];
                                o_bundle.slot[k[1:0]] = item;
                                k = k + 3'd1;
                            end
                            if (!n_pad[1]) begin
                                item.out_byte = n_bits[7:0];
                                o_bundle.slot[k[1:0]] = item;
                                k = k + 3'd1;
                            end
                        end
                        n_bits  = '0;
                        n_count = 2'd0;
                        n_pad   = 2'd0;
                    end else begin
                        n_count = pos + 2'd1;
                    end
                end
            end
            if (i_item.in_last) begin
                item = '0;
                item.out_last = 1'b1;
                if (n_err == b64sc_pkg::ST_BAD_CHAR) begin
                    item.status = b64sc_pkg::ST_BAD_CHAR;
                end else if (!n_seen) begin
                    item.status = b64sc_pkg::ST_BAD_PAD;
                end else if (n_count != 2'd0) begin
                    item.status = b64sc_pkg::ST_BAD_LEN;
                end else begin
                    item.status = n_err;
                end
                o_bundle.slot[k[1:0]] = item;
                k = k + 3'd1;
            end
            o_bundle.count = k;
        end

        if (i_item.in_last) begin
            n_bits  = '0;
            n_count = 2'd0;
            n_pad   = 2'd0;
            n_err   = b64sc_pkg::ST_OK;
            n_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_bits  <= '0;
            r_count <= 2'd0;
            r_pad   <= 2'd0;
            r_err   <= b64sc_pkg::ST_OK;
            r_seen  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode  <= i_cfg_data;
            r_bits  <= '0;
            r_count <= 2'd0;
            r_pad   <= 2'd0;
            r_err   <= b64sc_pkg::ST_OK;
            r_seen  <= 1'b0;
        end else if (i_load) begin
            r_bits  <= n_bits;
            r_count <= n_count;
            r_pad   <= n_pad;
            r_err   <= n_err;
            r_seen  <= n_seen;
        end
    end

endmodule

FILE: src/b64sc_outq.sv
`timescale 1ns / 1ps

module b64sc_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  b64sc_pkg::t_bundle   i_bundle,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64sc_pkg::t_out_item o_item
);

    b64sc_pkg::t_out_item r_slot [b64sc_pkg::MaxResults];
    logic [2:0]           r_rem;
    logic [1:0]           r_idx;
    logic                 r_out_valid;
    b64sc_pkg::t_out_item r_out;
    logic                 pop;

    assign pop    = (r_rem != 3'd0) && (!r_out_valid || i_ready);
    // The bundle may be refilled in the cycle its final entry moves out.
    assign o_free = (r_rem == 3'd0) || (r_rem == 3'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_rem <= i_bundle.count;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < b64sc_pkg::MaxResults; i++) begin
                r_slot[i] <= i_bundle.slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_slot[r_idx];
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: src/base64_stream_codec.sv
`timescale 1ns / 1ps

// Streaming base64 codec. Input transactions carry one byte and an end-of-stream
// mark on i_valid/o_ready; result transactions carry one character or byte,
// a has-byte flag, an end mark and a status on o_valid/i_ready.
// i_cfg_we writes the mode bit (0 encode, 1 decode) and clears the stream state;
// the user must write it only while the codec is idle, which is not enforced.
// The first result of a transaction passes the input register, then the result
// bundle, then the output register.
// Throughput is set by the single result port, one result per cycle while the
// receiver is ready, and by the result bundle, which takes the next transaction
// only as its final result moves out: in encoding, only the byte that closes a
// group or the stream gives results, four of them, and the bytes before it give
// none; in decoding, only the character that closes a group or the stream gives
// results, up to four.
// One input transaction is held while the previous one's results drain, so
// input and output run concurrently.
// Reset clears every register of control state and selects encode mode.
// When the receiver stalls, the output register holds its result, the bundle
// fills behind it and then o_ready drops; nothing is lost.
module base64_stream_codec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  b64sc_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64sc_pkg::t_out_item o_item
);

    logic                r_in_valid;
    b64sc_pkg::t_in_item r_in;
    logic                load;
    logic                q_free;
    b64sc_pkg::t_bundle  bundle;

    assign load    = r_in_valid && q_free;
    assign o_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    b64sc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_load     (load),
        .i_item     (r_in),
        .o_bundle   (bundle)
    );

    b64sc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (q_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item)
    );

endmodule

FILE: sim/tb_base64_stream_codec.sv
`timescale 1ns / 1ps

module tb_base64_stream_codec;

    localparam int IdlePct    = 36;
    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 8;
    localparam int MaxPrinted = 30;

    // Standard alphabet, first character in the top byte.
    localparam logic [8*64-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam logic ModeEncode = 1'b0;
    localparam logic ModeDecode = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    b64sc_pkg::t_in_item  i_item;
    logic                 o_valid;
    logic                 i_ready;
    b64sc_pkg::t_out_item o_item;

    base64_stream_codec DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // Shadow copy of the codec state.
    logic        mode_dec;
    logic [23:0] grp_bits;
    logic [1:0]  grp_count;
    logic [1:0]  pad_seen;
    logic [1:0]  err_code;
    logic        seen_char;

    b64sc_pkg::t_out_item expected_q[$];
    logic [7:0]           stream_buf[$];

    logic        free_run;
    int          cycle_count;
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          streams_enc;
    int          streams_dec;
    int          mode_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random unless a free-running stretch is in progress.
    always @(negedge i_clk) begin
        i_ready <= free_run || ($urandom_range(99) >= IdlePct);
    end

    function automatic logic [7:0] sym_of(input logic [5:0] v);
        return Alphabet[8*(63 - v) +: 8];
    endfunction

    // 0..63 for alphabet characters, 64 for the pad, 255 for anything else.
    function automatic int value_of(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (sym_of(6'(i)) == c) return i;
        end
        if (c == b64sc_pkg::PadChar) return 64;
        return 255;
    endfunction

    function automatic void clear_stream();
        grp_bits  = '0;
        grp_count = '0;
        pad_seen  = '0;
        err_code  = b64sc_pkg::ST_OK;
        seen_char = 1'b0;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic has,
                                        input logic last, input logic [1:0] st);
        b64sc_pkg::t_out_item r;
        r.out_byte = d;
        r.has_byte = has;
        r.out_last = last;
        r.status   = st;
        expected_q.push_back(r);
    endfunction

    // Works out the results caused by one accepted input transaction.
    function automatic void predict_item(input logic [7:0] d, input logic last);
        logic [1:0] pos;
        logic [1:0] st;
        int         v;
        if (mode_dec == ModeEncode) begin
            pos = (grp_count > 2'd2) ? 2'd0 : grp_count;
            grp_bits  = grp_bits | ({16'd0, d} << (16 - 8 * pos));
            grp_count = pos + 2'd1;
            if (grp_count == 2'd3) begin
                push_result(sym_of(grp_bits[23:18]), 1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result(sym_of(grp_bits[17:12]), 1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result(sym_of(grp_bits[11:6]), 1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result(sym_of(grp_bits[5:0]), 1'b1, last, b64sc_pkg::ST_OK);
                grp_bits  = '0;
                grp_count = '0;
            end else if (last) begin
                push_result(sym_of(grp_bits[23:18]), 1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result(sym_of(grp_bits[17:12]), 1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result((grp_count == 2'd2) ? sym_of(grp_bits[11:6])
                                                : b64sc_pkg::PadChar,
                            1'b1, 1'b0, b64sc_pkg::ST_OK);
                push_result(b64sc_pkg::PadChar, 1'b1, 1'b1, b64sc_pkg::ST_OK);
            end
        end else begin
            if (d != b64sc_pkg::SpaceChar && d != b64sc_pkg::NewlineChar) begin
                v = value_of(d);
                seen_char = 1'b1;
                if (v == 255) begin
                    err_code = b64sc_pkg::ST_BAD_CHAR;
                end else begin
                    pos = grp_count;
                    if (v == 64) begin
                        // A pad in the first two places poisons the stream but still
                        // occupies its place in the group.
                        if (pos < 2'd2) begin
                            if (err_code == b64sc_pkg::ST_OK) begin
                                err_code = b64sc_pkg::ST_BAD_PAD;
                            end
                        end else begin
                            pad_seen = pad_seen | ((pos == 2'd2) ? 2'b01 : 2'b10);
                        end
                        v = 0;
                    end
                    grp_bits = {grp_bits[17:0], 6'(v)};
                    if (pos == 2'd3) begin
                        if (err_code == b64sc_pkg::ST_OK) begin
                            push_result(grp_bits[23:16], 1'b1, 1'b0, b64sc_pkg::ST_OK);
                            if (!pad_seen[0]) begin
                                push_result(grp_bits[15:8], 1'b1, 1'b0, b64sc_pkg::ST_OK);
                            end
                            if (!pad_seen[1]) begin
                                push_result(grp_bits[7:0], 1'b1, 1'b0, b64sc_pkg::ST_OK);
                            end
                        end
                        grp_bits  = '0;
                        grp_count = '0;
                        pad_seen  = '0;
                    end else begin
                        grp_count = pos + 2'd1;
                    end
                end
            end
            if (last) begin
                if (err_code == b64sc_pkg::ST_BAD_CHAR) st = b64sc_pkg::ST_BAD_CHAR;
                else if (!seen_char)                    st = b64sc_pkg::ST_BAD_PAD;
                else if (grp_count != 2'd0)             st = b64sc_pkg::ST_BAD_LEN;
                else                                    st = err_code;
                push_result(8'h00, 1'b0, 1'b1, st);
            end
        end
        if (last) clear_stream();
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (result %0d)",
                                      name, got, want, results_seen));
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        b64sc_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%0h arrived with none expected", o_item));
            end else begin
                want = expected_q.pop_front();
                check_field("out_byte", o_item.out_byte, want.out_byte);
                check_field("has_byte", o_item.has_byte, want.has_byte);
                check_field("out_last", o_item.out_last, want.out_last);
                check_field("status", o_item.status, want.status);
            end
        end
    end

    // Sends one input transaction, after a random gap unless free-running, and predicts once it is taken.
    task automatic send_item(input logic [7:0] d, input logic last);
        int gap;
        gap = 0;
        if (!free_run) begin
            while ($urandom_range(99) < IdlePct && gap < 12) gap++;
        end
        @(negedge i_clk);
        while (gap > 0) begin
            i_valid <= 1'b0;
            gap--;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= {d, last};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(d, last);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_buf.size(); i++) begin
            send_item(stream_buf[i], i == stream_buf.size() - 1);
        end
        stream_buf.delete();
    endtask

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++) stream_buf.push_back(s[i]);
    endfunction

    // Inputs that give no result, such as whitespace, might still be in flight,
    // so the wait does not end at the last expected result.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_dec = m;
        clear_stream();
        mode_writes++;
    endtask

    function automatic logic [7:0] noise_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return b64sc_pkg::PadChar;
            2:       return $urandom_range(1) ? b64sc_pkg::SpaceChar
                                              : b64sc_pkg::NewlineChar;
            default: return sym_of(6'($urandom_range(63)));
        endcase
    endfunction

    function automatic void add_char(input logic [7:0] c);
        if ($urandom_range(9) == 0) begin
            stream_buf.push_back($urandom_range(1) ? b64sc_pkg::SpaceChar
                                                   : b64sc_pkg::NewlineChar);
        end
        stream_buf.push_back(c);
    endfunction

    // Mostly well-formed random text; a quarter of non-empty ones is damaged on purpose.
    function automatic void build_decode_text();
        int          nbytes;
        int          idx;
        logic [23:0] g;
        nbytes = $urandom_range(7);
        for (int i = 0; i < nbytes; i += 3) begin
            g = 24'($urandom);
            add_char(sym_of(g[23:18]));
            add_char(sym_of(g[17:12]));
            add_char((nbytes - i >= 2) ? sym_of(g[11:6]) : b64sc_pkg::PadChar);
            add_char((nbytes - i >= 3) ? sym_of(g[5:0]) : b64sc_pkg::PadChar);
        end
        if (stream_buf.size() > 0 && $urandom_range(99) < 25) begin
            idx = $urandom_range(stream_buf.size() - 1);
            case ($urandom_range(3))
                0:       stream_buf.insert(idx, noise_char());
                1:       stream_buf.delete(idx);
                2:       stream_buf[idx] = b64sc_pkg::PadChar;
                default: stream_buf[idx] = 8'($urandom_range(255));
            endcase
        end
        if (stream_buf.size() == 0 || $urandom_range(7) == 0) stream_buf.push_back(noise_char());
    endfunction

    task automatic test_encode_directed();
        load_text("Man");
        send_stream();
        // A lone byte needs two pads, two bytes need one.
        stream_buf.push_back(8'hFF);
        send_stream();
        stream_buf.push_back(8'h00);
        stream_buf.push_back(8'hFF);
        send_stream();
        streams_enc += 3;
    endtask

    // A mode write drops a half-gathered group.
    task automatic test_mode_write_midstream();
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        set_mode(ModeEncode);
        send_item(8'hFF, 1'b1);
        streams_enc++;
    endtask

    task automatic test_decode_directed();
        set_mode(ModeDecode);
        load_text("TQ=u");      // pad in third place, real fourth character
        send_stream();
        load_text("TQ==");
        send_stream();
        load_text("=AAA");      // pad in the first place
        send_stream();
        stream_buf.push_back(8'hFF);
        send_stream();
        load_text("\n");        // nothing but whitespace
        send_stream();
        load_text("Zm 9");      // three characters only
        send_stream();
        streams_dec += 6;
    endtask

    task automatic test_random_encode(input int n_items, input logic no_idle);
        int start;
        int len;
        start = items_sent;
        free_run = no_idle;
        set_mode(ModeEncode);
        while (items_sent - start < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
            repeat (len) stream_buf.push_back(8'($urandom_range(255)));
            send_stream();
            streams_enc++;
        end
        wait_idle();
        free_run = 1'b0;
    endtask

    task automatic test_random_decode(input int n_items);
        int start;
        start = items_sent;
        set_mode(ModeDecode);
        while (items_sent - start < n_items) begin
            build_decode_text();
            send_stream();
            streams_dec++;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        free_run    = 1'b0;
        items_sent  = 0;
        streams_enc = 0;
        streams_dec = 0;
        mode_writes = 0;
        mode_dec    = ModeEncode;
        clear_stream();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_encode_directed();
        test_mode_write_midstream();
        test_decode_directed();
        test_random_encode(60, 1'b1);
        test_random_decode(130);
        test_random_encode(50, 1'b0);
        test_random_decode(70);
        wait_idle();

        $display("Ran %0d encode and %0d decode streams, %0d input transactions, %0d results.",
                 streams_enc, streams_dec, items_sent, results_seen);
        $display("Mode register written %0d times; %0d mismatches.", mode_writes, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/b64sc_pkg.sv
src/b64sc_step.sv
src/b64sc_outq.sv
src/base64_stream_codec.sv
sim/tb_base64_stream_codec.sv
